FILE: sv/best_fit_page_allocator_top_macros.svh
// assertion macros for the page allocator checker
`ifndef BEST_FIT_PAGE_ALLOCATOR_TOP_MACROS_SVH
`define BEST_FIT_PAGE_ALLOCATOR_TOP_MACROS_SVH
// implication checked on every clock, held off during reset
`define BFPA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// next-cycle implication
`define BFPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

FILE: sv/bfpa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_pkg
// shared types and codes of the best-fit page allocator
// ----------------------------------------------------------------------------
package bfpa_pkg;
	localparam logic       REQ_ALLOC   = 1'b0;
	localparam logic       REQ_FREE    = 1'b1;
	localparam logic [1:0] ST_OK       = 2'd0;
	localparam logic [1:0] ST_BAD_SIZE = 2'd1;
	localparam logic [1:0] ST_NO_FIT   = 2'd2;
	localparam logic [1:0] ST_UNKNOWN  = 2'd3;

	// controller to datapath
	typedef struct packed {
		logic load;       // capture request
		logic scan_clr;   // clear scan state
		logic scan_step;  // look at one page
		logic rec_clr;    // start record search
		logic rec_step;   // look at one record
		logic mark_init;  // prepare page marking
		logic mark_step;  // write one page
		logic rec_write;  // write record for alloc
		logic rec_kill;   // invalidate found record
		logic mem_clr;    // clearing sweep step
	} bfpa_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_free;
		logic size_bad;
		logic scan_done;
		logic found;
		logic rec_done;
		logic rec_hit;
		logic mark_done;
		logic clr_done;
	} bfpa_sts_t;
endpackage

FILE: sv/best_fit_page_allocator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// best_fit_page_allocator_top
// best-fit allocator of heap pages with a start/length record table
// ----------------------------------------------------------------------------
// One item at a time. After reset a sweep clears the page map before the
// first item is taken. An allocate walks the page map through its single ram
// port, one page per cycle, stopping early on an exact fit, then writes one
// page per cycle for the granted length. A free walks the record table at one
// record per cycle, then releases one page per cycle. Failed requests finish
// after the scan or the record walk, or straight after the decide state for a
// bad size.
module best_fit_page_allocator_top #(
	parameter int HEAP_PAGES  = 1024,
	parameter int MAX_RECORDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        req_type,
	input  logic [31:0] size_bytes,
	input  logic [9:0]  free_page,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [9:0]  start_page,
	output logic [1:0]  status
);
	bfpa_pkg::bfpa_cmd_t cmd;
	bfpa_pkg::bfpa_sts_t sts;

	bfpa_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts)
	);

	bfpa_datapath #(.HEAP_PAGES(HEAP_PAGES), .MAX_RECORDS(MAX_RECORDS)) u_dp (
		.clk(clk), .arst_n(arst_n), .req_type(req_type), .size_bytes(size_bytes),
		.free_page(free_page), .cmd(cmd), .sts(sts), .res_ok(ok),
		.res_start(start_page), .res_status(status)
	);
endmodule

FILE: sv/bfpa_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
module bfpa_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

FILE: sv/bfpa_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_datapath
// page map, record table, run scanner and result register
// ----------------------------------------------------------------------------
module bfpa_datapath #(
	parameter int HEAP_PAGES  = 1024,
	parameter int MAX_RECORDS = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_type,
	input  logic [31:0]        size_bytes,
	input  logic [9:0]         free_page,
	input  bfpa_pkg::bfpa_cmd_t cmd,
	output bfpa_pkg::bfpa_sts_t sts,
	output logic               res_ok,
	output logic [9:0]         res_start,
	output logic [1:0]         res_status
);
	localparam int PW = $clog2(HEAP_PAGES);
	localparam int CW = PW + 1;            // page counts up to HEAP_PAGES
	localparam int RW = $clog2(MAX_RECORDS);
	localparam int SW = $clog2(HEAP_PAGES + 2);

	logic          type_q;
	logic [20:0]   need_q;                 // pages from 32-bit byte size
	logic [9:0]    fpage_q;
	logic          size_bad_q;

	// page map
	logic          pm_we;
	logic [PW-1:0] pm_addr;
	logic          pm_wdata;
	logic          pm_rdata;

	// scan, each page read is issued ahead of its use through the registered ram read
	logic [SW-1:0] scan_p_q;               // page whose data is now at rdata
	logic          scan_vld_q;
	logic [CW-1:0] run_len_q;
	logic [PW-1:0] run_start_q;
	logic [CW-1:0] best_len_q;
	logic [PW-1:0] best_start_q;
	logic          found_q;
	logic          scan_done_q;

	// records
	logic [RW-1:0] rec_idx_q;
	logic [RW:0]   rec_cnt_q;
	logic [MAX_RECORDS-1:0] rec_valid_q;
	logic          rec_rd_vld_q;
	logic [RW-1:0] rec_rd_idx_q;
	logic          rec_hit_q;
	logic [RW-1:0] hit_idx_q;
	logic [PW-1:0] hit_start_q;
	logic [CW-1:0] hit_len_q;
	logic          rec_done_q;
	logic          slot_found;
	logic [RW-1:0] slot_idx;
	logic          rs_we;
	logic [RW-1:0] rs_addr;
	logic [PW-1:0] rs_wdata;
	logic [PW-1:0] rs_rdata;
	logic [CW-1:0] rl_wdata;
	logic [CW-1:0] rl_rdata;

	// marking
	logic [PW-1:0] mark_p_q;
	logic [CW-1:0] mark_left_q;
	logic          mark_val_q;
	logic [PW-1:0] clr_p_q;
	logic          clr_done_q;

	logic          cur_free;
	logic          run_end;
	logic [CW-1:0] run_len_nx;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			type_q     <= req_type;
			need_q     <= 21'((33'(size_bytes) + 33'd4095) >> 12);
			fpage_q    <= free_page;
			size_bad_q <= (size_bytes == 32'd0) ||
				(((33'(size_bytes) + 33'd4095) >> 12) > 33'(HEAP_PAGES));
		end
	end

	assign cur_free   = (scan_p_q < SW'(HEAP_PAGES)) && !pm_rdata;
	assign run_end    = scan_vld_q && !cur_free;
	assign run_len_nx = run_len_q + CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_p_q    <= '0;
			scan_vld_q  <= 1'b0;
			scan_done_q <= 1'b0;
			found_q     <= 1'b0;
			run_len_q   <= '0;
		end else if (cmd.scan_clr) begin
			scan_p_q    <= '0;
			scan_vld_q  <= 1'b0;
			scan_done_q <= 1'b0;
			found_q     <= 1'b0;
			run_len_q   <= '0;
		end else if (cmd.scan_step && !scan_done_q) begin
			scan_vld_q <= 1'b1;
			if (scan_vld_q) begin
				scan_p_q <= scan_p_q + SW'(1);
				if (cur_free) begin
					run_len_q <= run_len_nx;
				end else begin
					run_len_q <= '0;
					if (run_len_q != '0) begin
						if (21'(run_len_q) == need_q) begin
							found_q <= 1'b1;
						end else if (21'(run_len_q) > need_q &&
							(!found_q || run_len_q < best_len_q)) begin
							found_q <= 1'b1;
						end
					end
				end
				if (run_end && ((run_len_q != '0 && 21'(run_len_q) == need_q) ||
					scan_p_q == SW'(HEAP_PAGES))) begin
					scan_done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_step && scan_vld_q && !scan_done_q) begin
			if (cur_free && run_len_q == '0) begin
				run_start_q <= PW'(scan_p_q);
			end
			if (!cur_free && run_len_q != '0 && (21'(run_len_q) == need_q ||
				(21'(run_len_q) > need_q && (!found_q || run_len_q < best_len_q)))) begin
				best_start_q <= run_start_q;
				best_len_q   <= run_len_q;
			end
		end
	end

	// lowest invalid slot
	always_comb begin
		slot_found = 1'b0;
		slot_idx   = '0;
		for (int i = MAX_RECORDS - 1; i >= 0; i--) begin
			if (!rec_valid_q[i]) begin
				slot_found = 1'b1;
				slot_idx   = RW'(i);
			end
		end
	end

	// free lookup walks the records, one read a cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rec_valid_q  <= '0;
			rec_cnt_q    <= '0;
			rec_rd_vld_q <= 1'b0;
			rec_hit_q    <= 1'b0;
			rec_done_q   <= 1'b0;
		end else begin
			if (cmd.rec_clr) begin
				rec_cnt_q    <= '0;
				rec_rd_vld_q <= 1'b0;
				rec_hit_q    <= 1'b0;
				rec_done_q   <= 1'b0;
			end else if (cmd.rec_step && !rec_done_q) begin
				rec_rd_vld_q <= (rec_cnt_q < (RW+1)'(MAX_RECORDS));
				if (rec_cnt_q < (RW+1)'(MAX_RECORDS)) begin
					rec_cnt_q <= rec_cnt_q + (RW+1)'(1);
				end
				if (rec_rd_vld_q && rec_valid_q[rec_rd_idx_q] &&
					32'(rs_rdata) == 32'(fpage_q)) begin
					rec_hit_q  <= 1'b1;
					rec_done_q <= 1'b1;
				end else if (rec_rd_vld_q && rec_cnt_q == (RW+1)'(MAX_RECORDS)) begin
					rec_done_q <= 1'b1;
				end
			end
			if (cmd.rec_write) begin
				rec_valid_q[slot_idx] <= 1'b1;
			end
			if (cmd.rec_kill) begin
				rec_valid_q[hit_idx_q] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		rec_rd_idx_q <= rec_idx_q;
		if (cmd.rec_step && rec_rd_vld_q && !rec_done_q) begin
			hit_idx_q   <= rec_rd_idx_q;
			hit_start_q <= rs_rdata;
			hit_len_q   <= rl_rdata;
		end
	end

	always_comb begin
		rec_idx_q = rec_cnt_q[RW-1:0];
	end

	assign rs_we    = cmd.rec_write;
	assign rs_addr  = cmd.rec_write ? slot_idx : rec_idx_q;
	assign rs_wdata = best_start_q;
	assign rl_wdata = CW'(need_q);

	bfpa_ram #(.WIDTH(PW), .DEPTH(MAX_RECORDS)) u_rec_start (
		.clk(clk), .we(rs_we), .addr(rs_addr), .wdata(rs_wdata), .rdata(rs_rdata)
	);
	bfpa_ram #(.WIDTH(CW), .DEPTH(MAX_RECORDS)) u_rec_len (
		.clk(clk), .we(rs_we), .addr(rs_addr), .wdata(rl_wdata), .rdata(rl_rdata)
	);

	// marking and clearing sweep
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_p_q     <= '0;
			clr_done_q  <= 1'b0;
			mark_left_q <= '0;
		end else begin
			if (cmd.mem_clr) begin
				clr_p_q <= clr_p_q + PW'(1);
				if (clr_p_q == PW'(HEAP_PAGES - 1)) begin
					clr_done_q <= 1'b1;
				end
			end
			if (cmd.mark_init) begin
				mark_left_q <= type_q ? hit_len_q : CW'(need_q);
			end else if (cmd.mark_step && mark_left_q != '0) begin
				mark_left_q <= mark_left_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mark_init) begin
			mark_p_q   <= type_q ? hit_start_q : best_start_q;
			mark_val_q <= !type_q;
		end else if (cmd.mark_step) begin
			mark_p_q <= mark_p_q + PW'(1);
		end
	end

	always_comb begin
		pm_we    = 1'b0;
		pm_wdata = 1'b0;
		pm_addr  = PW'(scan_p_q + SW'(scan_vld_q));
		if (cmd.mem_clr) begin
			pm_we   = 1'b1;
			pm_addr = clr_p_q;
		end else if (cmd.mark_step && mark_left_q != '0) begin
			pm_we    = 1'b1;
			pm_wdata = mark_val_q;
			pm_addr  = mark_p_q;
		end
	end

	bfpa_ram #(.WIDTH(1), .DEPTH(HEAP_PAGES)) u_page_map (
		.clk(clk), .we(pm_we), .addr(pm_addr), .wdata(pm_wdata), .rdata(pm_rdata)
	);

	// result register, a granted item is never overwritten by a failure code
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			res_ok <= 1'b0;
		end
		if (cmd.mark_init) begin
			res_ok     <= 1'b1;
			res_status <= bfpa_pkg::ST_OK;
			res_start  <= type_q ? 10'd0 : 10'(best_start_q);
		end else if (!res_ok && cmd.rec_write == 1'b0 && cmd.scan_step == 1'b0 &&
			cmd.rec_step == 1'b0 && cmd.mark_step == 1'b0 && cmd.load == 1'b0 &&
			cmd.mem_clr == 1'b0 && cmd.rec_kill == 1'b0) begin
			if (type_q == bfpa_pkg::REQ_FREE && rec_done_q && !rec_hit_q) begin
				res_ok <= 1'b0; res_start <= 10'd0; res_status <= bfpa_pkg::ST_UNKNOWN;
			end else if (type_q == bfpa_pkg::REQ_ALLOC && size_bad_q) begin
				res_ok <= 1'b0; res_start <= 10'd0; res_status <= bfpa_pkg::ST_BAD_SIZE;
			end else if (type_q == bfpa_pkg::REQ_ALLOC && scan_done_q &&
				(!found_q || !slot_found)) begin
				res_ok <= 1'b0; res_start <= 10'd0; res_status <= bfpa_pkg::ST_NO_FIT;
			end
		end
	end

	assign sts.is_free   = type_q;
	assign sts.size_bad  = size_bad_q;
	assign sts.scan_done = scan_done_q;
	assign sts.found     = found_q && slot_found;
	assign sts.rec_done  = rec_done_q;
	assign sts.rec_hit   = rec_hit_q;
	assign sts.mark_done = (mark_left_q == '0);
	assign sts.clr_done  = clr_done_q;
endmodule

FILE: sv/bfpa_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bfpa_ctrl
// sequencer for allocate and free requests
// ----------------------------------------------------------------------------
module bfpa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	output logic                out_valid,
	input  logic                out_stall,
	output bfpa_pkg::bfpa_cmd_t cmd,
	input  bfpa_pkg::bfpa_sts_t sts
);
	localparam logic [3:0] S_CLEAR  = 4'd0;
	localparam logic [3:0] S_IDLE   = 4'd1;
	localparam logic [3:0] S_DECIDE = 4'd2;
	localparam logic [3:0] S_SCAN   = 4'd3;
	localparam logic [3:0] S_REC    = 4'd4;
	localparam logic [3:0] S_MINIT  = 4'd5;
	localparam logic [3:0] S_MARK   = 4'd6;
	localparam logic [3:0] S_FAIL   = 4'd7;
	localparam logic [3:0] S_OUT    = 4'd8;

	logic [3:0] state_q;
	logic [3:0] state_nx;
	logic       out_valid_q;

	always_comb begin
		cmd      = '0;
		state_nx = state_q;
		unique case (state_q)
			S_CLEAR: begin
				cmd.mem_clr = 1'b1;
				if (sts.clr_done) begin
					cmd.mem_clr = 1'b0;
					state_nx    = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid && !out_valid_q) begin
					cmd.load     = 1'b1;
					cmd.scan_clr = 1'b1;
					cmd.rec_clr  = 1'b1;
					state_nx     = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if (sts.is_free) begin
					state_nx = S_REC;
				end else if (sts.size_bad) begin
					state_nx = S_FAIL;
				end else begin
					state_nx = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.scan_done) begin
					state_nx = sts.found ? S_MINIT : S_FAIL;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_REC: begin
				if (sts.rec_done) begin
					state_nx = sts.rec_hit ? S_MINIT : S_FAIL;
				end else begin
					cmd.rec_step = 1'b1;
				end
			end
			S_MINIT: begin
				cmd.mark_init = 1'b1;
				cmd.rec_write = !sts.is_free;
				cmd.rec_kill  = sts.is_free;
				state_nx      = S_MARK;
			end
			S_MARK: begin
				cmd.mark_step = 1'b1;
				if (sts.mark_done) begin
					cmd.mark_step = 1'b0;
					state_nx      = S_OUT;
				end
			end
			S_FAIL: begin
				state_nx = S_OUT;
			end
			S_OUT: begin
				state_nx = S_IDLE;
			end
			default: begin
				state_nx = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (state_q == S_OUT) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall  = (state_q != S_IDLE) || out_valid_q;
	assign out_valid = out_valid_q;
endmodule

FILE: sv/bfpa_checker.sv
`timescale 1ns / 1ps
`include "best_fit_page_allocator_top_macros.svh"
// ----------------------------------------------------------------------------
// bfpa_checker
// port-level checks of the page allocator
// ----------------------------------------------------------------------------
module bfpa_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic       ok,
	input logic [9:0] start_page,
	input logic [1:0] status
);
	// one item in flight: no input taken while a result waits
	`BFPA_ASSERT_IMPL(a_no_accept_busy, clk, arst_n, out_valid, in_stall)
	// ok agrees with the status code
	`BFPA_ASSERT_IMPL(a_ok_status, clk, arst_n, out_valid, ok == (status == bfpa_pkg::ST_OK))
	// failures carry start page zero
	`BFPA_ASSERT_IMPL(a_fail_zero, clk, arst_n, out_valid && !ok, start_page == 10'd0)
	// a stalled result stays
	`BFPA_ASSERT_NEXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(status))
endmodule

bind best_fit_page_allocator_top bfpa_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.out_valid(out_valid), .out_stall(out_stall), .ok(ok),
	.start_page(start_page), .status(status)
);

FILE: dv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the best-fit page allocator
// ----------------------------------------------------------------------------
// A queue of pending requests feeds a clocked driver. A page map and record
// table model in the bench works out the grant of every accepted item, and the
// monitor compares each result with the oldest one waiting. Directed corner
// requests come first, then a fill of the record table, then a random mix of
// allocates and frees under changing handshake idling.
// ----------------------------------------------------------------------------
module tb;
	localparam int HEAP   = 1024;
	localparam int NREC   = 64;
	localparam int LIMIT  = 6000000;
	localparam int TAIL   = 2400;

	typedef enum logic [1:0] {K_ALLOC, K_FREE_LIVE, K_FREE_PAGE, K_PAUSE} kind_t;

	typedef struct {
		kind_t       kind;
		logic [31:0] size;
		logic [9:0]  page;
	} req_t;

	typedef struct {
		logic       ok;
		logic [9:0] start;
		logic [1:0] st;
	} grant_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        req_type = bfpa_pkg::REQ_ALLOC;
	logic [31:0] size_bytes = '0;
	logic [9:0]  free_page = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        ok;
	logic [9:0]  start_page;
	logic [1:0]  status;

	best_fit_page_allocator_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.req_type(req_type), .size_bytes(size_bytes), .free_page(free_page),
		.out_valid(out_valid), .out_stall(out_stall),
		.ok(ok), .start_page(start_page), .status(status)
	);

	always #6 clk = ~clk;

	// allocator model state
	bit         page_used [HEAP];
	logic [9:0] rec_start [NREC];
	int         rec_len   [NREC];
	bit         rec_valid [NREC];

	req_t   pending_reqs[$];
	grant_t expected_grants[$];
	int     n_accepted = 0;
	int     n_results = 0;
	int     n_mismatch = 0;
	int     n_granted = 0;
	int     n_freed = 0;
	int     n_refused = 0;
	int     cycles = 0;
	int     idle_mode = 0;
	int     hold_left = 0;
	bit     hold_done = 0;
	bit     acc_now = 0;

	function automatic grant_t allocate_pages(logic [31:0] size);
		grant_t g;
		logic [32:0] need;
		int run_s, run_l, best_s, best_l, slot;
		bit found, exact;
		g = '{1'b0, 10'd0, bfpa_pkg::ST_BAD_SIZE};
		need = ({1'b0, size} + 33'd4095) >> 12;
		run_s = 0; run_l = 0; best_s = 0; best_l = 0; slot = -1;
		found = 0; exact = 0;
		if (size == 0 || need > HEAP)
			return g;
		for (int p = 0; p <= HEAP && !exact; p++) begin
			if (p < HEAP && !page_used[p]) begin
				if (run_l == 0)
					run_s = p;
				run_l++;
			end else begin
				if (run_l != 0) begin
					if (run_l == need) begin
						best_s = run_s; best_l = run_l; found = 1; exact = 1;
					end else if (run_l > need && (!found || run_l < best_l)) begin
						best_s = run_s; best_l = run_l; found = 1;
					end
				end
				run_l = 0;
			end
		end
		for (int i = NREC - 1; i >= 0; i--)
			if (!rec_valid[i])
				slot = i;
		g.st = bfpa_pkg::ST_NO_FIT;
		if (!found || slot < 0)
			return g;
		for (int p = 0; p < need; p++)
			page_used[best_s + p] = 1;
		rec_start[slot] = best_s[9:0];
		rec_len[slot] = int'(need);
		rec_valid[slot] = 1;
		return '{1'b1, best_s[9:0], bfpa_pkg::ST_OK};
	endfunction

	function automatic grant_t release_block(logic [9:0] page);
		for (int i = 0; i < NREC; i++) begin
			if (rec_valid[i] && rec_start[i] == page) begin
				for (int p = 0; p < rec_len[i]; p++)
					if (rec_start[i] + p < HEAP)
						page_used[rec_start[i] + p] = 0;
				rec_valid[i] = 0;
				return '{1'b1, 10'd0, bfpa_pkg::ST_OK};
			end
		end
		return '{1'b0, 10'd0, bfpa_pkg::ST_UNKNOWN};
	endfunction

	function automatic logic [9:0] pick_live_start();
		int live[$];
		for (int i = 0; i < NREC; i++)
			if (rec_valid[i])
				live.push_back(i);
		if (live.size() == 0)
			return 10'($urandom);
		return rec_start[live[$urandom_range(0, live.size() - 1)]];
	endfunction

	// driver
	always @(negedge clk) begin
		req_t r;
		bit   give;
		int   pct;
		give = 0;
		pct = (idle_mode == 0) ? 38 : (idle_mode == 1) ? 66 : 0;
		if (in_valid && !acc_now) begin
			give = 1;
		end else if (pending_reqs.size() != 0) begin
			if (pending_reqs[0].kind == K_PAUSE) begin
				if (expected_grants.size() == 0 && !out_valid)
					void'(pending_reqs.pop_front());
			end else if ($urandom_range(0, 99) >= pct) begin
				r = pending_reqs.pop_front();
				give = 1;
				req_type <= (r.kind == K_ALLOC) ? bfpa_pkg::REQ_ALLOC : bfpa_pkg::REQ_FREE;
				size_bytes <= r.size;
				free_page <= (r.kind == K_FREE_LIVE) ? pick_live_start() : r.page;
			end
		end
		in_valid <= give;
		acc_now = 0;
	end

	// receiver stall, with one long hold to back up the input
	always @(negedge clk) begin
		int pct;
		pct = (idle_mode == 0) ? 66 : (idle_mode == 1) ? 38 : 0;
		if (!hold_done && n_accepted == 100) begin
			hold_done = 1;
			hold_left = 3000;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(0, 99) < pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		grant_t g;
		if (arst_n && in_valid && !in_stall) begin
			acc_now = 1;
			n_accepted++;
			idle_mode = (n_accepted < 180) ? 0 : (n_accepted < 360) ? 1 : 2;
			if (req_type == bfpa_pkg::REQ_ALLOC)
				g = allocate_pages(size_bytes);
			else
				g = release_block(free_page);
			expected_grants.push_back(g);
		end
		if (arst_n && out_valid && !out_stall) begin
			n_results++;
			if (expected_grants.size() == 0) begin
				n_mismatch++;
				if (n_mismatch <= 10)
					$display("unexpected result ok=%0d start=%0d status=%0d",
						ok, start_page, status);
			end else begin
				g = expected_grants.pop_front();
				if (g.ok && g.start != 0)
					n_granted++;
				if (g.ok && g.start == 0)
					n_freed++;
				if (!g.ok)
					n_refused++;
				if (ok !== g.ok || start_page !== g.start || status !== g.st) begin
					n_mismatch++;
					if (n_mismatch <= 10)
						$display({"result %0d: expected ok=%0d start=%0d status=%0d,",
							" got ok=%0d start=%0d status=%0d"},
							n_results, g.ok, g.start, g.st, ok, start_page, status);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Mismatches found");
			$finish;
		end
	end

	task automatic push_alloc(logic [31:0] sz);
		pending_reqs.push_back('{K_ALLOC, sz, 10'($urandom)});
	endtask

	task automatic push_free(logic [9:0] pg);
		pending_reqs.push_back('{K_FREE_PAGE, $urandom, pg});
	endtask

	task automatic push_free_live();
		pending_reqs.push_back('{K_FREE_LIVE, $urandom, 10'd0});
	endtask

	initial begin
		int r;
		for (int i = 0; i < HEAP; i++)
			page_used[i] = 0;
		for (int i = 0; i < NREC; i++)
			rec_valid[i] = 0;

		// directed corners
		push_alloc(32'd0);
		push_alloc(32'hFFFF_FFFF);
		push_alloc(32'd4194305);
		push_alloc(32'd4194304);
		push_alloc(32'd1);
		push_free(10'd1023);
		push_free(10'd0);
		push_alloc(32'd4096);
		push_alloc(32'd4097);
		push_alloc(32'd12288);
		push_free(10'd1);
		push_alloc(32'd8192);
		push_free(10'd0);
		push_alloc(32'd1);
		push_free(10'd1);
		push_free(10'd1);
		push_free(10'd1023);
		push_free(10'd512);
		push_alloc(32'h8000_0000);
		for (int i = 0; i < 4; i++)
			push_free_live();

		// fill the record table past its capacity, then drain part of it
		for (int i = 0; i < 68; i++)
			push_alloc($urandom_range(1, 12000));
		for (int i = 0; i < 30; i++)
			push_free_live();

		for (int i = 0; i < 420; i++) begin
			if (i == 200)
				pending_reqs.push_back('{K_PAUSE, 32'd0, 10'd0});
			r = $urandom_range(0, 99);
			if (r < 40)
				push_alloc($urandom_range(1, 16 * 4096));
			else if (r < 47)
				push_alloc($urandom_range(1, 200 * 4096));
			else if (r < 50)
				push_alloc($urandom_range(1, HEAP * 4096));
			else if (r < 54)
				push_alloc($urandom_range(HEAP * 4096 + 1, 32'hFFFF_FFFF));
			else if (r < 56)
				push_alloc(32'd0);
			else if (r < 88)
				push_free_live();
			else
				push_free(10'($urandom));
		end

		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		wait (pending_reqs.size() == 0 && !in_valid && expected_grants.size() == 0);
		repeat (TAIL) @(posedge clk);
		$display({"%0d items accepted, %0d results: %0d grants at nonzero pages,",
			" %0d frees or page-0 grants, %0d refusals"},
			n_accepted, n_results, n_granted, n_freed, n_refused);
		$display("covered size and free corners, record table overflow, long output hold and a drain pause");
		if (n_mismatch == 0 && expected_grants.size() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+sv
sv/bfpa_pkg.sv
sv/bfpa_ram.sv
sv/bfpa_datapath.sv
sv/bfpa_ctrl.sv
sv/best_fit_page_allocator_top.sv
sv/bfpa_checker.sv
dv/tb.sv
